>>> rtl/fcrd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the framed control report demultiplexer.
package fcrd_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
    localparam logic [7:0]  FRAME_BYTE  = 8'h55;
    localparam logic [15:0] AXIS_BIAS   = 16'h8000;
    localparam logic [3:0]  HAT_CENTER  = 4'hF;
    localparam int          HAT_STEPS   = 8;
    localparam int          REPORT_LEN  = 34;
    localparam int          BUTTON_BYTES = 16;
    localparam int          MAX_BUTTONS = 128;
    localparam int          MAX_AXES    = 8;
    localparam int          MAX_HATS    = 4;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_AXIS   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_HAT    = 2'd2,
        KIND_NONE   = 2'd3
    } bind_kind_t;

    typedef enum logic [1:0] {
        CMD_FWD1  = 2'd0,
        CMD_FWD2  = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_BIND  = 2'd3
    } cmd_op_t;

    // FWD: arg[7:0] byte. FRAME: {value, id}. BIND: {slot, live, kind, id, target}.
    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] arg;
    } cmd_t;

    typedef struct packed {
        bind_kind_t  kind;
        logic [15:0] id;
        logic [7:0]  target;
    } bind_ent_t;

endpackage

>>> rtl/fcrd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/fcrd_front.sv
`timescale 1ns / 1ps
// Front end: accepts transactions, parses the byte stream and queues commands.
module fcrd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [7:0]          serial_data,
    input  logic [4:0]          bind_slot,
    input  logic                bind_valid,
    input  logic [1:0]          bind_kind,
    input  logic [15:0]         bind_control_id,
    input  logic [7:0]          bind_target,
    input  logic                q_full,
    output logic                q_push,
    output fcrd_pkg::cmd_t      q_cmd
);
    import fcrd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SYNC  = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  fb_reg [3];
    logic        fb_we;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        fb_we      = 1'b0;
        q_push     = 1'b0;
        q_cmd.op   = CMD_FWD1;
        q_cmd.arg  = {24'd0, serial_data};
        if (accept)
        begin
            if (action)
            begin
                q_push    = 1'b1;
                q_cmd.op  = CMD_BIND;
                q_cmd.arg = {bind_slot, bind_valid, bind_kind, bind_control_id, bind_target};
            end
            else
            begin
                unique case (phase_reg)
                    PH_SYNC:
                    begin
                        phase_next = PH_IDLE;
                        if (serial_data == FRAME_BYTE)
                        begin
                            phase_next = PH_FRAME;
                            cnt_next   = 2'd0;
                        end
                        else
                        begin
                            q_push   = 1'b1;
                            q_cmd.op = CMD_FWD2;
                        end
                    end
                    PH_FRAME:
                    begin
                        if (cnt_reg != 2'd3)
                        begin
                            fb_we    = 1'b1;
                            cnt_next = cnt_reg + 2'd1;
                        end
                        else
                        begin
                            q_push     = 1'b1;
                            q_cmd.op   = CMD_FRAME;
                            q_cmd.arg  = {serial_data, fb_reg[2], fb_reg[1], fb_reg[0]};
                            cnt_next   = 2'd0;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        if (serial_data == SYNC_BYTE)
                        begin
                            phase_next = PH_SYNC;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            q_push     = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_reg[cnt_reg] <= serial_data;
        end
    end

    a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> (phase_reg == PH_FRAME))
        else $error("frame byte count set outside a frame");

endmodule

>>> rtl/fcrd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the parser and the report engine.
module fcrd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fcrd_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output fcrd_pkg::cmd_t  q_cmd
);
    import fcrd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("command queue underflow");

endmodule

>>> rtl/fcrd_back.sv
`timescale 1ns / 1ps
// Back end: binding table, report state, binding walk and result emission.
module fcrd_back #(
    parameter int BINDINGS     = 32,
    parameter int AXIS_COUNT   = 8,
    parameter int BUTTON_COUNT = 128,
    parameter int HAT_COUNT    = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  fcrd_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_kind,
    output logic [7:0]      out_data,
    output logic            last_of_run
);
    import fcrd_pkg::*;

    localparam int IDXW = (BINDINGS > 1) ? $clog2(BINDINGS) : 1;
    localparam int CW   = $clog2(BINDINGS + 1);
    localparam int BW   = $clog2(BUTTON_COUNT);
    localparam int AXW  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int HW   = (HAT_COUNT > 1) ? $clog2(HAT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FWD  = 2'd1,
        S_WALK = 2'd2,
        S_EMIT = 2'd3
    } state_t;

    state_t                  state_reg;
    logic [BINDINGS-1:0]     live_reg;
    logic [BUTTON_COUNT-1:0] btn_reg;
    logic [15:0]             axis_reg [AXIS_COUNT];
    logic [3:0]              hat_reg [HAT_COUNT];
    logic [15:0]             frame_id_reg;
    logic [15:0]             frame_val_reg;
    logic [CW-1:0]           rd_cnt_reg;
    logic                    chk_valid_reg;
    logic [IDXW-1:0]         chk_idx_reg;
    logic                    hit_reg;
    logic [5:0]              emit_cnt_reg;
    logic [7:0]              fwd_byte_reg;
    logic                    fwd_two_reg;
    logic                    fwd_cnt_reg;
    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [7:0]              out_data_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    out_load;
    logic                    bind_we;
    logic                    slot_ok;
    logic [IDXW-1:0]         bind_addr;
    logic                    rd_en;
    logic [IDXW-1:0]         rd_addr;
    logic [$bits(bind_ent_t)-1:0] rd_word;
    bind_ent_t               ent;
    logic                    match;
    logic [3:0]              hat_nib;
    logic [MAX_BUTTONS-1:0]  btn_full;
    logic [4*MAX_HATS-1:0]   hat_full;
    logic [15:0]             axis_full [MAX_AXES];
    logic [5:0]              ax_off;
    logic [7:0]              report_byte;
    logic                    report_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && ((state_reg == S_FWD) || (state_reg == S_EMIT));
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign slot_ok   = int'(q_cmd.arg[31:27]) < BINDINGS;
    assign bind_we   = q_pop && (q_cmd.op == CMD_BIND) && slot_ok;
    assign bind_addr = IDXW'(q_cmd.arg[31:27]);
    assign rd_en     = (state_reg == S_WALK) && (rd_cnt_reg < CW'(BINDINGS));
    assign rd_addr   = rd_cnt_reg[IDXW-1:0];

    fcrd_ram #(
        .WIDTH ($bits(bind_ent_t)),
        .DEPTH (BINDINGS)
    ) u_bind_ram (
        .clk     (clk),
        .wr_en   (bind_we),
        .wr_addr (bind_addr),
        .wr_data (q_cmd.arg[$bits(bind_ent_t)-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign ent   = bind_ent_t'(rd_word);
    assign match = live_reg[chk_idx_reg] && (ent.kind != KIND_NONE)
                   && (ent.id == frame_id_reg);

    always_comb
    begin
        if (frame_val_reg == 16'd0 || frame_val_reg > 16'(HAT_STEPS))
        begin
            hat_nib = HAT_CENTER;
        end
        else
        begin
            hat_nib = 4'(frame_val_reg - 16'd1);
        end
    end

    // Unstored targets read back as their reset value.
    always_comb
    begin
        btn_full = '0;
        btn_full[BUTTON_COUNT-1:0] = btn_reg;
        hat_full = '1;
        for (int h = 0; h < HAT_COUNT; h++)
        begin
            hat_full[4*h +: 4] = hat_reg[h];
        end
        for (int a = 0; a < MAX_AXES; a++)
        begin
            axis_full[a] = 16'd0;
        end
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            axis_full[a] = axis_reg[a];
        end
    end

    assign ax_off      = emit_cnt_reg - 6'(BUTTON_BYTES + 2);
    assign report_last = (emit_cnt_reg == 6'(REPORT_LEN - 1));

    always_comb
    begin
        priority if (emit_cnt_reg < 6'(BUTTON_BYTES))
        begin
            report_byte = btn_full[{emit_cnt_reg[3:0], 3'b000} +: 8];
        end
        else if (emit_cnt_reg == 6'(BUTTON_BYTES))
        begin
            report_byte = hat_full[7:0];
        end
        else if (emit_cnt_reg == 6'(BUTTON_BYTES + 1))
        begin
            report_byte = hat_full[15:8];
        end
        else if (ax_off[0])
        begin
            report_byte = axis_full[ax_off[3:1]][15:8];
        end
        else
        begin
            report_byte = axis_full[ax_off[3:1]][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            btn_reg       <= '0;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                axis_reg[a] <= 16'd0;
            end
            for (int h = 0; h < HAT_COUNT; h++)
            begin
                hat_reg[h] <= HAT_CENTER;
            end
            frame_id_reg  <= 16'd0;
            frame_val_reg <= 16'd0;
            rd_cnt_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            emit_cnt_reg  <= 6'd0;
            fwd_byte_reg  <= 8'd0;
            fwd_two_reg   <= 1'b0;
            fwd_cnt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_data_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_cmd.op)
                            CMD_FWD1, CMD_FWD2:
                            begin
                                fwd_byte_reg <= q_cmd.arg[7:0];
                                fwd_two_reg  <= (q_cmd.op == CMD_FWD2);
                                fwd_cnt_reg  <= 1'b0;
                                state_reg    <= S_FWD;
                            end
                            CMD_FRAME:
                            begin
                                frame_id_reg  <= q_cmd.arg[15:0];
                                frame_val_reg <= q_cmd.arg[31:16];
                                rd_cnt_reg    <= '0;
                                chk_valid_reg <= 1'b0;
                                hit_reg       <= 1'b0;
                                state_reg     <= S_WALK;
                            end
                            CMD_BIND:
                            begin
                                if (slot_ok)
                                begin
                                    live_reg[bind_addr] <= q_cmd.arg[26];
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_FWD:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= 1'b0;
                        if (fwd_two_reg && !fwd_cnt_reg)
                        begin
                            out_data_reg <= SYNC_BYTE;
                            out_last_reg <= 1'b0;
                            fwd_cnt_reg  <= 1'b1;
                        end
                        else
                        begin
                            out_data_reg <= fwd_byte_reg;
                            out_last_reg <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end
                end

                S_WALK:
                begin
                    // Read slot n while checking slot n-1.
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    end
                    chk_valid_reg <= rd_en;
                    chk_idx_reg   <= rd_addr;
                    if (chk_valid_reg && match)
                    begin
                        hit_reg <= 1'b1;
                        unique case (ent.kind)
                            KIND_AXIS:
                            begin
                                if (int'(ent.target) < AXIS_COUNT)
                                begin
                                    axis_reg[ent.target[AXW-1:0]] <= frame_val_reg ^ AXIS_BIAS;
                                end
                            end
                            KIND_BUTTON:
                            begin
                                if (int'(ent.target) < BUTTON_COUNT)
                                begin
                                    btn_reg[ent.target[BW-1:0]] <= (frame_val_reg != 16'd0);
                                end
                            end
                            KIND_HAT:
                            begin
                                if (int'(ent.target) < HAT_COUNT)
                                begin
                                    hat_reg[ent.target[HW-1:0]] <= hat_nib;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (!rd_en && !chk_valid_reg)
                    begin
                        emit_cnt_reg <= 6'd0;
                        state_reg    <= hit_reg ? S_EMIT : S_IDLE;
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= 1'b1;
                        out_data_reg  <= report_byte;
                        out_last_reg  <= report_last;
                        emit_cnt_reg  <= emit_cnt_reg + 6'd1;
                        if (report_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_data    = out_data_reg;
    assign last_of_run = out_last_reg;

    a_chk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_WALK))
        else $error("binding check outside the walk");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_cnt_reg < 6'(REPORT_LEN)))
        else $error("report byte counter past report end");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CW'(BINDINGS))
        else $error("binding walk past table end");

endmodule

>>> rtl/framed_control_report_demux_core.sv
`timescale 1ns / 1ps
// Top level of the framed control report demultiplexer.
// Forwarded byte: queued, then sent out by the report engine; the second byte of a
// broken opener follows a re-sent sync byte.
// Binding write: taken by the report engine, no result.
// Complete frame: the binding RAM is walked one slot per cycle, then, if any binding
// matched, 34 report bytes go out at one per cycle while the receiver is ready.
module framed_control_report_demux_core #(
    parameter int BINDINGS     = 32,
    parameter int AXIS_COUNT   = 8,
    parameter int BUTTON_COUNT = 128,
    parameter int HAT_COUNT    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  serial_data,
    input  logic [4:0]  bind_slot,
    input  logic        bind_valid,
    input  logic [1:0]  bind_kind,
    input  logic [15:0] bind_control_id,
    input  logic [7:0]  bind_target,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_data,
    output logic        last_of_run
);
    import fcrd_pkg::*;

    // Reset clears parser, queue, live bits and report (hats centered); binding RAM is not
    // cleared.

    logic  push;
    cmd_t  push_cmd;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    cmd_t  q_cmd;

    fcrd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .serial_data     (serial_data),
        .bind_slot       (bind_slot),
        .bind_valid      (bind_valid),
        .bind_kind       (bind_kind),
        .bind_control_id (bind_control_id),
        .bind_target     (bind_target),
        .q_full          (q_full),
        .q_push          (push),
        .q_cmd           (push_cmd)
    );

    fcrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    fcrd_back #(
        .BINDINGS     (BINDINGS),
        .AXIS_COUNT   (AXIS_COUNT),
        .BUTTON_COUNT (BUTTON_COUNT),
        .HAT_COUNT    (HAT_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_data    (out_data),
        .last_of_run (last_of_run)
    );

endmodule

>>> dv/fcrd_report_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the demultiplexer, predicts every output transaction and checks it.
module fcrd_report_checker
    import fcrd_pkg::*;
#(
    parameter int BINDINGS     = 32,
    parameter int AXIS_COUNT   = 8,
    parameter int BUTTON_COUNT = 128,
    parameter int HAT_COUNT    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [7:0]  serial_data,
    input  logic [4:0]  bind_slot,
    input  logic        bind_valid,
    input  logic [1:0]  bind_kind,
    input  logic [15:0] bind_control_id,
    input  logic [7:0]  bind_target,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_kind,
    input  logic [7:0]  out_data,
    input  logic        last_of_run,
    output int          mismatches,
    output int          outstanding
);

    typedef enum logic [1:0] {
        PARSE_IDLE  = 2'd0,
        PARSE_SYNC  = 2'd1,
        PARSE_FRAME = 2'd2
    } parse_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    parse_state_t parse_state;
    logic [1:0]   frame_pos;
    logic [7:0]   frame_buf [3];
    logic [7:0]   buttons [BUTTON_BYTES];
    logic [7:0]   hats [2];
    logic [15:0]  axes [MAX_AXES];
    logic         slot_live [BINDINGS];
    bind_kind_t   slot_kind [BINDINGS];
    logic [15:0]  slot_id [BINDINGS];
    logic [7:0]   slot_target [BINDINGS];
    out_byte_t    expected_bytes [$];
    int           err_count;

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] report mismatch: %s", $time, msg);
    endtask

    task automatic queue_byte(input logic kind, input logic [7:0] data, input logic last);
        out_byte_t b;
        b.kind = kind;
        b.data = data;
        b.last = last;
        expected_bytes.push_back(b);
    endtask

    task automatic update_control(input bind_kind_t kind, input logic [7:0] tgt,
                                  input logic [15:0] value);
        logic [3:0] nib;
        case (kind)
            KIND_AXIS:
                if (tgt < AXIS_COUNT)
                    axes[tgt[2:0]] = value ^ AXIS_BIAS;
            KIND_BUTTON:
                if (tgt < BUTTON_COUNT)
                    buttons[tgt[6:3]][tgt[2:0]] = (value != 16'd0);
            KIND_HAT:
                if (tgt < HAT_COUNT) begin
                    nib = (value == 16'd0 || value > HAT_STEPS) ? HAT_CENTER : value[3:0] - 4'd1;
                    if (tgt[0])
                        hats[tgt[1]][7:4] = nib;
                    else
                        hats[tgt[1]][3:0] = nib;
                end
            default: ;
        endcase
    endtask

    // Work out the output transactions caused by one accepted input transaction.
    task automatic predict_demux();
        logic [15:0] id;
        logic [15:0] value;
        logic        hit;
        if (action) begin
            if (bind_slot < BINDINGS) begin
                slot_live[bind_slot]   = bind_valid;
                slot_kind[bind_slot]   = bind_kind_t'(bind_kind);
                slot_id[bind_slot]     = bind_control_id;
                slot_target[bind_slot] = bind_target;
            end
            return;
        end
        case (parse_state)
            PARSE_SYNC: begin
                if (serial_data == FRAME_BYTE) begin
                    frame_pos   = 2'd0;
                    parse_state = PARSE_FRAME;
                end else begin
                    queue_byte(1'b0, SYNC_BYTE, 1'b0);
                    queue_byte(1'b0, serial_data, 1'b1);
                    parse_state = PARSE_IDLE;
                end
            end
            PARSE_FRAME: begin
                if (frame_pos < 2'd3) begin
                    frame_buf[frame_pos] = serial_data;
                    frame_pos++;
                end else begin
                    id    = {frame_buf[1], frame_buf[0]};
                    value = {serial_data, frame_buf[2]};
                    hit   = 1'b0;
                    // Ascending slot order: a later slot wins on a shared target.
                    for (int s = 0; s < BINDINGS; s++) begin
                        if (slot_live[s] && slot_kind[s] != KIND_NONE && slot_id[s] == id) begin
                            update_control(slot_kind[s], slot_target[s], value);
                            hit = 1'b1;
                        end
                    end
                    frame_pos   = 2'd0;
                    parse_state = PARSE_IDLE;
                    if (hit) begin
                        for (int k = 0; k < BUTTON_BYTES; k++)
                            queue_byte(1'b1, buttons[k], 1'b0);
                        queue_byte(1'b1, hats[0], 1'b0);
                        queue_byte(1'b1, hats[1], 1'b0);
                        for (int k = 0; k < MAX_AXES; k++) begin
                            queue_byte(1'b1, axes[k][7:0], 1'b0);
                            queue_byte(1'b1, axes[k][15:8], k == MAX_AXES - 1);
                        end
                    end
                end
            end
            default: begin
                parse_state = PARSE_IDLE;
                if (serial_data == SYNC_BYTE)
                    parse_state = PARSE_SYNC;
                else
                    queue_byte(1'b0, serial_data, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_byte_t want;
        out_byte_t got;
        if (!rst_n) begin
            parse_state = PARSE_IDLE;
            frame_pos   = 2'd0;
            for (int k = 0; k < BUTTON_BYTES; k++)
                buttons[k] = 8'h00;
            hats[0] = 8'hFF;
            hats[1] = 8'hFF;
            for (int k = 0; k < MAX_AXES; k++)
                axes[k] = 16'h0000;
            for (int k = 0; k < BINDINGS; k++)
                slot_live[k] = 1'b0;
            expected_bytes.delete();
            err_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            // Results trail their cause by cycles, so check before predicting.
            if (out_valid && out_ready) begin
                got.kind = out_kind;
                got.data = out_data;
                got.last = last_of_run;
                if (expected_bytes.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction kind %0d data %02h last %0d",
                                            got.kind, got.data, got.last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data
                            || got.last !== want.last)
                        note_mismatch($sformatf(
                            "expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
                            want.kind, want.data, want.last, got.kind, got.data, got.last));
                end
            end
            if (in_valid && in_ready)
                predict_demux();
            mismatches  <= err_count;
            outstanding <= expected_bytes.size();
        end
    end

endmodule

>>> dv/tb_framed_control_report_demux_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the framed control report demultiplexer, with checker beside the block.
module tb_framed_control_report_demux_core;
    import fcrd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [7:0]  serial_data = 8'h00;
    logic [4:0]  bind_slot = 5'd0;
    logic        bind_valid = 1'b0;
    logic [1:0]  bind_kind = 2'd0;
    logic [15:0] bind_control_id = 16'h0000;
    logic [7:0]  bind_target = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_kind;
    logic [7:0]  out_data;
    logic        last_of_run;

    int          mismatches;
    int          outstanding;
    int          sent_count;
    bit          idle_on;
    bit          stall_on;
    logic [15:0] id_pool [4];

    framed_control_report_demux_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .serial_data(serial_data), .bind_slot(bind_slot),
        .bind_valid(bind_valid), .bind_kind(bind_kind), .bind_control_id(bind_control_id),
        .bind_target(bind_target),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_kind(out_kind), .out_data(out_data), .last_of_run(last_of_run)
    );

    fcrd_report_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .serial_data(serial_data), .bind_slot(bind_slot),
        .bind_valid(bind_valid), .bind_kind(bind_kind), .bind_control_id(bind_control_id),
        .bind_target(bind_target),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_kind(out_kind), .out_data(out_data), .last_of_run(last_of_run),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one transaction and hold it until accepted; valid stays high on return.
    task automatic send_item(input logic act, input logic [7:0] data, input logic [4:0] slot,
                             input logic live, input logic [1:0] kind, input logic [15:0] id,
                             input logic [7:0] tgt);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        serial_data     <= data;
        bind_slot       <= slot;
        bind_valid      <= live;
        bind_kind       <= kind;
        bind_control_id <= id;
        bind_target     <= tgt;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_binding(input logic [4:0] slot, input logic live, input bind_kind_t kind,
                                input logic [15:0] id, input logic [7:0] tgt);
        send_item(1'b1, 8'($urandom_range(0, 255)), slot, live, kind, id, tgt);
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [15:0] value);
        send_byte(SYNC_BYTE);
        send_byte(FRAME_BYTE);
        send_byte(id[7:0]);
        send_byte(id[15:8]);
        send_byte(value[7:0]);
        send_byte(value[15:8]);
    endtask

    // Drop valid and hold until every predicted output transaction has arrived.
    task automatic drain_reports();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 6) == 0)
            return 16'($urandom_range(0, 65535));
        return id_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'($urandom_range(1, 8));
            2: return 16'd9;
            3: return 16'hFFFF;
            4: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_target(input bind_kind_t kind);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        case (kind)
            KIND_AXIS:   return 8'($urandom_range(0, MAX_AXES - 1));
            KIND_BUTTON: return 8'($urandom_range(0, MAX_BUTTONS - 1));
            KIND_HAT:    return 8'($urandom_range(0, MAX_HATS - 1));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver side: random stall bursts while enabled.
    initial begin
        @(posedge clk iff rst_n);
        forever begin
            if (stall_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        bind_kind_t kind;
        int         pick;
        sent_count = 0;
        idle_on    = 1'b1;
        stall_on   = 1'b1;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'($urandom_range(0, 65535));
        id_pool[3] = 16'($urandom_range(0, 65535));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_binding(5'd0, 1'b1, KIND_AXIS, 16'h1234, 8'd0);
        send_binding(5'd31, 1'b1, KIND_BUTTON, 16'h1234, 8'd127);
        send_binding(5'd2, 1'b1, KIND_HAT, 16'h1234, 8'd3);
        // Reserved kind never matches; out-of-range axis still forces a report.
        send_binding(5'd3, 1'b1, KIND_NONE, 16'hFFFF, 8'd0);
        send_binding(5'd4, 1'b1, KIND_AXIS, 16'hFFFF, 8'd255);
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'h12);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_frame(16'h1234, 16'hFFFF);
        send_frame(16'hFFFF, 16'd8);
        send_frame(16'hBEEF, 16'h0000);
        drain_reports();

        while (sent_count < 300) begin
            if (sent_count > 240) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end else if ($urandom_range(0, 12) == 0) begin
                idle_on  = $urandom_range(0, 1);
                stall_on = $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_frame(pick_id(), pick_value());
            end else if (pick < 62) begin
                kind = bind_kind_t'($urandom_range(0, 3));
                send_binding(5'($urandom_range(0, 31)), $urandom_range(0, 3) != 0, kind,
                             pick_id(), pick_target(kind));
            end else if (pick < 72) begin
                // Broken frame opener, or a sync followed by random noise.
                send_byte(SYNC_BYTE);
                send_byte($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if (sent_count <= 240 && $urandom_range(0, 30) == 0)
                drain_reports();
        end

        drain_reports();
        repeat (80) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fcrd_pkg.sv
rtl/fcrd_ram.sv
rtl/fcrd_front.sv
rtl/fcrd_queue.sv
rtl/fcrd_back.sv
rtl/framed_control_report_demux_core.sv
dv/fcrd_report_checker.sv
dv/tb_framed_control_report_demux_core.sv
